### rtl/core/dbc_pkg.sv
`default_nettype none
package dbc_pkg;

  localparam int ID_W      = 6;   // out_id / item_id width
  localparam int SIZE_W    = 7;   // batch_size width, holds 1..64
  localparam int TICK_W    = 16;  // debounce countdown width
  localparam logic [TICK_W-1:0] DEBOUNCE_RST = 16'd100;

  typedef enum logic [1:0] {
    KIND_SCHED = 2'd0,
    KIND_TICK  = 2'd1,
    KIND_FORCE = 2'd2
  } dbc_kind_t;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_DRAIN = 1'b1
  } dbc_state_t;

  // controller -> datapath
  typedef struct packed {
    logic take;   // input word accepted, apply schedule/tick
    logic start;  // begin a batch: latch size, disarm, rewind scan
    logic emit;   // load output register from scan position
    logic step;   // advance scan position
  } dbc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic fire;      // current input word triggers a flush
    logic empty;     // nothing pending
    logic bit_set;   // scan position is pending
    logic one_left;  // one identifier left in batch
    logic out_free;  // output register can take a word
  } dbc_sts_t;

endpackage
`default_nettype wire

### rtl/core/dbc_ctrl.sv
`default_nettype none
module dbc_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  dbc_pkg::dbc_sts_t    sts,
  output dbc_pkg::dbc_cmd_t    cmd
);
  import dbc_pkg::*;

  dbc_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && sts.fire && !sts.empty) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (sts.bit_set && sts.out_free && sts.one_left) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready  = 1'b0;
    cmd.take  = 1'b0;
    cmd.start = 1'b0;
    cmd.emit  = 1'b0;
    cmd.step  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.take  = in_valid;
        cmd.start = in_valid && sts.fire;
      end
      ST_DRAIN: begin
        if (sts.bit_set) begin
          cmd.emit = sts.out_free;
          cmd.step = sts.out_free;
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

### rtl/core/dbc_dp.sv
`default_nettype none
module dbc_dp #(
  parameter int ID_COUNT = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_valid,
  input  wire logic [dbc_pkg::TICK_W-1:0]   cfg_data,
  input  wire logic [1:0]                   in_kind,
  input  wire logic [dbc_pkg::ID_W-1:0]     in_item_id,
  input  dbc_pkg::dbc_cmd_t                 cmd,
  output dbc_pkg::dbc_sts_t                 sts,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [dbc_pkg::ID_W-1:0]          out_id,
  output logic                              out_last,
  output logic [dbc_pkg::SIZE_W-1:0]        out_size
);
  import dbc_pkg::*;

  localparam int IW = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;

  logic [TICK_W-1:0]   debounce_r;
  logic [ID_COUNT-1:0] map_r, map_nxt;
  logic [SIZE_W-1:0]   count_r, count_nxt;   // ids added since last batch start
  logic [SIZE_W-1:0]   remain_r, remain_nxt;
  logic [SIZE_W-1:0]   size_r, size_nxt;
  logic [TICK_W-1:0]   ticks_r, ticks_nxt;
  logic                armed_r, armed_nxt;
  logic [IW-1:0]       scan_r, scan_nxt;
  logic                ovalid_r, ovalid_nxt;
  logic [ID_W-1:0]     oid_r;
  logic                olast_r;
  logic [SIZE_W-1:0]   osize_r;

  logic                in_range;
  logic                is_sched, is_tick, is_force;
  logic [TICK_W-1:0]   tick_dec;
  logic                newly_set;

  always_comb begin
    is_sched = 1'b0;
    is_tick  = 1'b0;
    is_force = 1'b0;
    case (in_kind)
      KIND_SCHED: is_sched = 1'b1;
      KIND_TICK:  is_tick  = 1'b1;
      KIND_FORCE: is_force = 1'b1;
      default:    is_sched = 1'b0;
    endcase
  end

  assign in_range  = ({1'b0, in_item_id} < SIZE_W'(ID_COUNT));
  assign newly_set = in_range && !map_r[in_item_id[IW-1:0]];
  assign tick_dec  = (ticks_r != '0) ? ticks_r - TICK_W'(1) : ticks_r;

  assign sts.fire     = is_force || (is_tick && armed_r && (tick_dec == '0));
  assign sts.empty    = (count_r == '0);
  assign sts.bit_set  = map_r[scan_r];
  assign sts.one_left = (remain_r == SIZE_W'(1));
  assign sts.out_free = !ovalid_r || out_ready;

  always_comb begin
    map_nxt    = map_r;
    count_nxt  = count_r;
    remain_nxt = remain_r;
    size_nxt   = size_r;
    ticks_nxt  = ticks_r;
    armed_nxt  = armed_r;
    scan_nxt   = scan_r;
    ovalid_nxt = ovalid_r && !out_ready;

    if (cmd.take && is_sched) begin
      for (int i = 0; i < ID_COUNT; i++) begin
        if (in_range && (in_item_id == ID_W'(i))) begin
          map_nxt[i] = 1'b1;
        end
      end
      if (newly_set) begin
        count_nxt = count_r + SIZE_W'(1);
      end
      ticks_nxt = debounce_r;
      armed_nxt = 1'b1;
    end
    if (cmd.take && is_tick && armed_r) begin
      ticks_nxt = tick_dec;
    end
    if (cmd.start) begin
      armed_nxt  = 1'b0;
      size_nxt   = count_r;
      remain_nxt = count_r;
      count_nxt  = '0;
      scan_nxt   = '0;
    end
    if (cmd.emit) begin
      for (int i = 0; i < ID_COUNT; i++) begin
        if (scan_r == IW'(i)) begin
          map_nxt[i] = 1'b0;
        end
      end
      remain_nxt = remain_r - SIZE_W'(1);
      ovalid_nxt = 1'b1;
    end
    if (cmd.step) begin
      scan_nxt = scan_r + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DEBOUNCE_RST;
      map_r      <= '0;
      count_r    <= '0;
      remain_r   <= '0;
      size_r     <= '0;
      ticks_r    <= '0;
      armed_r    <= 1'b0;
      scan_r     <= '0;
      ovalid_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        debounce_r <= cfg_data;
      end
      map_r    <= map_nxt;
      count_r  <= count_nxt;
      remain_r <= remain_nxt;
      size_r   <= size_nxt;
      ticks_r  <= ticks_nxt;
      armed_r  <= armed_nxt;
      scan_r   <= scan_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // output payload, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      oid_r   <= ID_W'(scan_r);
      olast_r <= (remain_r == SIZE_W'(1));
      osize_r <= size_r;
    end
  end

  assign out_valid = ovalid_r;
  assign out_id    = oid_r;
  assign out_last  = olast_r;
  assign out_size  = osize_r;

endmodule
`default_nettype wire

### rtl/core/debounced_id_batch_coalescer_core.sv
`default_nettype none
// Debounced identifier batch coalescer.
// Input stream (in_*): in_tuser carries kind (schedule, tick, force flush),
// in_tdata carries the identifier. Schedule marks the identifier pending and
// reloads/arms the debounce countdown; tick counts an armed countdown down;
// reaching zero, or a force word, flushes the pending set.
// Output stream (out_*): one word per pending identifier, ascending order,
// out_tlast on the final one, batch size alongside in out_tdata.
// Config (cfg_*): debounce length in ticks, always ready, write while idle.
// Throughput: schedule/tick words are taken every cycle while no drain is running.
// A flush word is taken, then the input is held off while the scan walks the
// pending map one identifier slot per cycle, waiting while the output register
// is full; the first result is registered when its slot is reached, and the
// drain ends on the last pending slot.
// An empty set flushes without a drain and without results.
// Reset (rst_n, sync): nothing pending, timer disarmed, debounce = 100.
// Receiver stall: the output register holds its word and the scan waits at the next pending slot.
module debounced_id_batch_coalescer_core #(
  parameter int ID_COUNT = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // config write
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data,    // debounce_ticks
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,    // [5:0] item_id, [7:6] zero
  input  wire logic [1:0]  in_tuser,    // [1:0] kind
  // output stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,   // [5:0] out_id, [12:6] batch_size, [15:13] zero
  output logic             out_tlast    // batch_last
);
  import dbc_pkg::*;

  dbc_cmd_t          cmd;
  dbc_sts_t          sts;
  logic [ID_W-1:0]   out_id;
  logic [SIZE_W-1:0] out_size;

  // register writes are to happen only while idle, which the block does not enforce; no back-pressure
  assign cfg_ready = 1'b1;

  dbc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dbc_dp #(
    .ID_COUNT (ID_COUNT)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .in_kind    (in_tuser),
    .in_item_id (in_tdata[ID_W-1:0]),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_id     (out_id),
    .out_last   (out_tlast),
    .out_size   (out_size)
  );

  assign out_tdata = {3'b000, out_size, out_id};

endmodule
`default_nettype wire

### tb/sv/tb_debounced_id_batch_coalescer_core.sv
`default_nettype none
module tb_debounced_id_batch_coalescer_core;
  timeunit 1ns;
  timeprecision 1ps;

  import dbc_pkg::*;

  localparam int ID_COUNT      = 64;
  localparam logic [1:0] KIND_RSVD = 2'd3;   // unused kind, block must ignore it
  localparam int PRED          = -1;         // table row: take results from predictor
  localparam int SETTLE_CYCLES = 2 * ID_COUNT + 8;  // covers one full scan plus slack
  localparam int HOLD_CYCLES   = 400;        // long receiver back-off
  localparam int CYCLE_LIMIT   = 300000;
  localparam int GAP_PCT       = 18;

  // One result word as the block should emit it.
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic              last;
    logic [SIZE_W-1:0] size;
  } id_word_t;

  // Directed stimulus row. Either a debounce write or one input word.
  // n_typed >= 0 means the results are written out here (0 or 1 word);
  // PRED means the predictor supplies them.
  typedef struct {
    bit                is_cfg;
    logic [TICK_W-1:0] cfg_val;
    logic [1:0]        kind;
    logic [ID_W-1:0]   id;
    int                n_typed;
    logic [ID_W-1:0]   t_id;
    logic [SIZE_W-1:0] t_size;
  } step_row_t;

  // ---------------------------------------------------------------------------
  // Clock, reset, DUT
  // ---------------------------------------------------------------------------
  logic clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  logic              rst_n      = 1'b0;
  logic              cfg_valid  = 1'b0;
  logic              cfg_ready;
  logic [15:0]       cfg_data   = '0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [7:0]        in_tdata   = '0;   // [5:0] item_id, [7:6] zero
  logic [1:0]        in_tuser   = '0;   // [1:0] kind
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [15:0]       out_tdata;         // [5:0] out_id, [12:6] batch_size, [15:13] zero
  logic              out_tlast;         // batch_last

  debounced_id_batch_coalescer_core #(
    .ID_COUNT(ID_COUNT)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  // ---------------------------------------------------------------------------
  // Shared testbench state
  // ---------------------------------------------------------------------------
  id_word_t  due_ids[$];      // words the block still owes, oldest first
  step_row_t plan[$];         // directed stimulus
  int        mismatches  = 0;
  int        items_sent  = 0; // counts words that can change state
  int        cyc         = 0;
  bit        gappy       = 1'b1;  // random idling on both sides
  logic      hold_req    = 1'b0;  // ask receiver for its long back-off

  // Predictor state: mirror of the pending set and debounce timer.
  logic [63:0]       pend_map;
  logic [TICK_W-1:0] ticks_left;
  logic              timer_armed;
  logic [TICK_W-1:0] debounce_len;

  task automatic flag_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Emit every pending id low to high, last one flagged, then clear and disarm.
  function automatic void flush_set(ref id_word_t batch[$]);
    int total;
    int k;
    int i;
    id_word_t w;
    total = $countones(pend_map);
    k = 0;
    for (i = 0; i < ID_COUNT; i++) begin
      if (pend_map[i]) begin
        k++;
        w.id   = i[ID_W-1:0];
        w.last = (k == total);
        w.size = total[SIZE_W-1:0];
        batch.push_back(w);
      end
    end
    pend_map    = '0;
    timer_armed = 1'b0;
  endfunction

  function automatic void coalesce_step(input logic [1:0] kind, input logic [ID_W-1:0] id,
                                        ref id_word_t batch[$]);
    case (kind)
      KIND_SCHED: begin
        // reload + arm even on a duplicate id
        if (id < ID_COUNT) pend_map[id] = 1'b1;
        ticks_left  = debounce_len;
        timer_armed = 1'b1;
      end
      KIND_TICK: begin
        if (timer_armed) begin
          // zero debounce: count stays at 0 and the tick fires at once
          if (ticks_left != 0) ticks_left = ticks_left - 1'b1;
          if (ticks_left == 0) flush_set(batch);
        end
      end
      KIND_FORCE: begin
        // remaining count left as is, only the arm bit drops
        flush_set(batch);
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Offer one word, wait for the handshake, then book what it should cause.
  // in_tvalid stays high across back-to-back words; it drops only for a gap or a settle.
  task automatic send_word(input logic [1:0] kind, input logic [ID_W-1:0] id,
                           input int n_typed = PRED,
                           input logic [ID_W-1:0] t_id = '0,
                           input logic [SIZE_W-1:0] t_size = '0);
    id_word_t batch[$];
    if (gappy && $urandom_range(99) < GAP_PCT) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {2'b00, id};
    do @(posedge clk); while (!in_tready);
    coalesce_step(kind, id, batch);
    if (n_typed == PRED) begin
      foreach (batch[i]) due_ids.push_back(batch[i]);
    end else if (n_typed == 1) begin
      due_ids.push_back('{t_id, 1'b1, t_size});
    end
    if (kind != KIND_RSVD) items_sent++;
  endtask

  // Drop valid, let every owed word drain, then idle for a slack period.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (due_ids.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [TICK_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    debounce_len = val;
  endtask

  // Random traffic: mostly schedule bursts that end in a timeout or a force,
  // the rest stray ticks, lone forces, unused kinds and lone schedules.
  task automatic run_batches(input int budget);
    int stop_at;
    int guard;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 15) begin
        case ($urandom_range(3))
          0:       send_word(KIND_TICK,  ID_W'($urandom_range(63)));
          1:       send_word(KIND_FORCE, ID_W'($urandom_range(63)));
          2:       send_word(KIND_RSVD,  ID_W'($urandom_range(63)));
          default: send_word(KIND_SCHED, ID_W'($urandom_range(63)));
        endcase
      end else begin
        repeat ($urandom_range(1, 6)) send_word(KIND_SCHED, ID_W'($urandom_range(63)));
        if (debounce_len > 8 || $urandom_range(3) == 0) begin
          send_word(KIND_FORCE, ID_W'($urandom_range(63)));
        end else begin
          // tick it out; an occasional schedule in between reloads the count
          guard = 0;
          while (timer_armed && guard < 40) begin
            if ($urandom_range(9) == 0) send_word(KIND_SCHED, ID_W'($urandom_range(63)));
            else                        send_word(KIND_TICK,  ID_W'($urandom_range(63)));
            guard++;
          end
        end
      end
    end
  endtask

  // Every id in a scrambled order, then a force while the receiver backs off.
  // The sender keeps offering words, so the drain stalls and in_tready drops.
  task automatic full_set_under_hold();
    logic [ID_W-1:0] mask;
    int i;
    mask = ID_W'($urandom_range(63));
    for (i = 0; i < ID_COUNT; i++) send_word(KIND_SCHED, i[ID_W-1:0] ^ mask);
    hold_req <= 1'b1;
    send_word(KIND_FORCE, ID_W'($urandom_range(63)));
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: check every accepted word against the oldest expectation
  // ---------------------------------------------------------------------------
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin : rx_side
    id_word_t want;
    if (out_tvalid && out_tready) begin
      if (due_ids.size() == 0) begin
        flag_mismatch($sformatf("unexpected word id=%0d size=%0d last=%0b",
                                out_tdata[5:0], out_tdata[12:6], out_tlast));
      end else begin
        want = due_ids.pop_front();
        if (out_tdata[5:0] !== want.id)
          flag_mismatch($sformatf("out_id %0d, want %0d", out_tdata[5:0], want.id));
        if (out_tlast !== want.last)
          flag_mismatch($sformatf("batch_last %0b, want %0b (id %0d)",
                                  out_tlast, want.last, want.id));
        if (out_tdata[12:6] !== want.size)
          flag_mismatch($sformatf("batch_size %0d, want %0d (id %0d)",
                                  out_tdata[12:6], want.size, want.id));
        if (out_tdata[15:13] !== 3'b000)
          flag_mismatch($sformatf("pad bits %b not zero", out_tdata[15:13]));
      end
    end

    // ready for next edge: long hold first, else random stalls
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done  <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (gappy) begin
      out_tready <= ($urandom_range(99) >= GAP_PCT);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= CYCLE_LIMIT) begin
      $display("tb_debounced_id_batch_coalescer_core: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    pend_map     = '0;
    ticks_left   = '0;
    timer_armed  = 1'b0;
    debounce_len = DEBOUNCE_RST;

    // Directed part, debounce at its reset value of 100 until the first write.
    plan.push_back('{0, '0, KIND_FORCE, 6'd0,  0, '0, '0});        // force on empty set
    plan.push_back('{0, '0, KIND_TICK,  6'd63, 0, '0, '0});        // tick while idle
    plan.push_back('{0, '0, KIND_RSVD,  6'd63, 0, '0, '0});        // unused kind
    plan.push_back('{0, '0, KIND_SCHED, 6'd63, 0, '0, '0});
    plan.push_back('{0, '0, KIND_FORCE, 6'd21, 1, 6'd63, 7'd1});   // force while armed
    plan.push_back('{0, '0, KIND_SCHED, 6'd0,  0, '0, '0});
    plan.push_back('{0, '0, KIND_SCHED, 6'd0,  0, '0, '0});        // duplicate id
    plan.push_back('{0, '0, KIND_FORCE, 6'd42, 1, 6'd0, 7'd1});
    plan.push_back('{0, '0, KIND_SCHED, 6'd42, PRED, '0, '0});
    plan.push_back('{0, '0, KIND_SCHED, 6'd63, PRED, '0, '0});
    plan.push_back('{0, '0, KIND_SCHED, 6'd1,  PRED, '0, '0});
    plan.push_back('{0, '0, KIND_TICK,  6'd0,  PRED, '0, '0});     // 100 -> 99, no fire
    plan.push_back('{0, '0, KIND_FORCE, 6'd0,  PRED, '0, '0});     // three-id batch
    plan.push_back('{0, '0, KIND_FORCE, 6'd63, 0, '0, '0});        // set already empty
    plan.push_back('{1, 16'd0, KIND_SCHED, '0, 0, '0, '0});        // zero debounce
    plan.push_back('{0, '0, KIND_SCHED, 6'd9,  0, '0, '0});
    plan.push_back('{0, '0, KIND_TICK,  6'd0,  1, 6'd9, 7'd1});    // fires on first tick
    plan.push_back('{0, '0, KIND_TICK,  6'd0,  0, '0, '0});        // disarmed again
    plan.push_back('{1, 16'd2, KIND_SCHED, '0, 0, '0, '0});
    plan.push_back('{0, '0, KIND_SCHED, 6'd4,  PRED, '0, '0});
    plan.push_back('{0, '0, KIND_TICK,  6'd0,  PRED, '0, '0});
    plan.push_back('{0, '0, KIND_SCHED, 6'd4,  PRED, '0, '0});     // reload on same id
    plan.push_back('{0, '0, KIND_TICK,  6'd0,  PRED, '0, '0});
    plan.push_back('{0, '0, KIND_TICK,  6'd0,  PRED, '0, '0});     // fires here
    plan.push_back('{0, '0, KIND_SCHED, 6'd21, PRED, '0, '0});
    plan.push_back('{0, '0, KIND_SCHED, 6'd42, PRED, '0, '0});
    plan.push_back('{0, '0, KIND_FORCE, 6'd0,  PRED, '0, '0});

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[r]) begin
      if (plan[r].is_cfg) begin
        settle();
        write_cfg(plan[r].cfg_val);
      end else begin
        send_word(plan[r].kind, plan[r].id, plan[r].n_typed, plan[r].t_id, plan[r].t_size);
      end
    end

    // Longest debounce: the timer never runs out, batches leave by force.
    settle();
    write_cfg(16'hFFFF);
    run_batches(10);

    // Zero debounce, both sides running flat out.
    settle();
    write_cfg(16'd0);
    gappy = 1'b0;
    run_batches(15);
    gappy = 1'b1;

    // Full 64-id batch against a stalled receiver.
    settle();
    write_cfg(16'd1);
    full_set_under_hold();
    run_batches(10);

    settle();
    write_cfg(TICK_W'($urandom_range(2, 6)));
    run_batches(15);

    settle();
    write_cfg(16'd3);
    run_batches(15);

    settle();
    if (mismatches == 0) begin
      $display("tb_debounced_id_batch_coalescer_core: PASS");
    end else begin
      $display("tb_debounced_id_batch_coalescer_core: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
